// ===== hw/rtl/tpd_pkg.sv =====
// Shared types and constants of the triangle plane dedup block.
package tpd_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned DiffW  = 17;
  localparam int unsigned NormW  = 35;
  localparam int unsigned MagW   = 34;
  localparam int unsigned HalfW  = 17;
  localparam int unsigned OpW    = 18;
  localparam int unsigned ProdW  = 2 * OpW;
  localparam int unsigned AccW   = 72;
  localparam int unsigned RootW  = 36;
  localparam int unsigned SqRemW = 40;
  localparam int unsigned DvRemW = 37;
  localparam int unsigned QuoW   = 15;
  localparam int unsigned UnitW  = 16;
  localparam int unsigned OffW   = 17;
  localparam int unsigned FracW  = 14;
  localparam int unsigned EntryW = 3 * UnitW + OffW;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CROSS_M,
    ST_CROSS_A,
    ST_CHECK,
    ST_SQ_M,
    ST_SQ_A,
    ST_SQRT_INIT,
    ST_SQRT,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_DIV_WR,
    ST_DOT_M,
    ST_DOT_A,
    ST_OFF,
    ST_SRCH_INIT,
    ST_SRCH,
    ST_TBL_WR,
    ST_OUT
  } tpd_state_e;

  typedef enum logic [3:0] {
    OP_UX, OP_UY, OP_UZ,
    OP_VX, OP_VY, OP_VZ,
    OP_MH, OP_ML,
    OP_UN0, OP_UN1, OP_UN2,
    OP_AX, OP_AY, OP_AZ
  } opsel_e;

  typedef enum logic [1:0] {
    SH_0,
    SH_18,
    SH_34
  } shift_e;

  typedef struct packed {
    logic       load;
    logic       mul_go;
    opsel_e     sel_a;
    opsel_e     sel_b;
    logic       acc_en;
    logic       acc_clr;
    logic       acc_sub;
    shift_e     acc_sh;
    logic [1:0] comp;
    logic       n_wr;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       un_wr;
    logic       off_wr;
    logic       srch_init;
    logic       srch_step;
    logic       tbl_wr;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic nz;
    logic srch_done;
    logic out_busy;
  } dp_sts_t;

endpackage

// ===== hw/rtl/tpd_ctrl.sv =====
// Sequencing state machine of the triangle plane dedup block.
module tpd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tpd_pkg::dp_sts_t sts_i,
  output tpd_pkg::dp_cmd_t cmd_o
);
  import tpd_pkg::*;

  localparam int unsigned KW = 6;
  localparam logic [KW-1:0] CrossLast = KW'(5);
  localparam logic [KW-1:0] SqLast    = KW'(8);
  localparam logic [KW-1:0] SqrtLast  = KW'(RootW - 1);
  localparam logic [KW-1:0] DivLast   = KW'(QuoW - 1);
  localparam logic [KW-1:0] DotLast   = KW'(2);

  tpd_state_e state_q, state_d;
  logic [KW-1:0] k_q, k_d;
  logic [1:0] comp_q, comp_d;
  logic [1:0] sq_comp;
  logic [1:0] sq_j;

  always_comb begin
    unique case (k_q)
      KW'(0), KW'(1), KW'(2): sq_comp = 2'd0;
      KW'(3), KW'(4), KW'(5): sq_comp = 2'd1;
      default:                sq_comp = 2'd2;
    endcase
    unique case (k_q)
      KW'(0), KW'(3), KW'(6): sq_j = 2'd0;
      KW'(1), KW'(4), KW'(7): sq_j = 2'd1;
      default:                sq_j = 2'd2;
    endcase
  end

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    comp_d  = comp_q;
    unique case (state_q)
      ST_IDLE: begin
        k_d = '0;
        if (in_valid_i) state_d = ST_CROSS_M;
      end
      ST_CROSS_M: state_d = ST_CROSS_A;
      ST_CROSS_A: begin
        if (k_q == CrossLast) begin
          k_d = '0;
          state_d = ST_CHECK;
        end else begin
          k_d = k_q + KW'(1);
          state_d = ST_CROSS_M;
        end
      end
      ST_CHECK: state_d = sts_i.nz ? ST_SQ_M : ST_OUT;
      ST_SQ_M: state_d = ST_SQ_A;
      ST_SQ_A: begin
        if (k_q == SqLast) begin
          k_d = '0;
          state_d = ST_SQRT_INIT;
        end else begin
          k_d = k_q + KW'(1);
          state_d = ST_SQ_M;
        end
      end
      ST_SQRT_INIT: state_d = ST_SQRT;
      ST_SQRT: begin
        if (k_q == SqrtLast) begin
          k_d = '0;
          comp_d = '0;
          state_d = ST_DIV_INIT;
        end else begin
          k_d = k_q + KW'(1);
        end
      end
      ST_DIV_INIT: begin
        k_d = '0;
        state_d = ST_DIV_STEP;
      end
      ST_DIV_STEP: begin
        if (k_q == DivLast) state_d = ST_DIV_WR;
        else k_d = k_q + KW'(1);
      end
      ST_DIV_WR: begin
        k_d = '0;
        if (comp_q == 2'd2) begin
          state_d = ST_DOT_M;
        end else begin
          comp_d = comp_q + 2'd1;
          state_d = ST_DIV_INIT;
        end
      end
      ST_DOT_M: state_d = ST_DOT_A;
      ST_DOT_A: begin
        if (k_q == DotLast) begin
          state_d = ST_OFF;
        end else begin
          k_d = k_q + KW'(1);
          state_d = ST_DOT_M;
        end
      end
      ST_OFF: state_d = ST_SRCH_INIT;
      ST_SRCH_INIT: state_d = ST_SRCH;
      ST_SRCH: if (sts_i.srch_done) state_d = ST_TBL_WR;
      ST_TBL_WR: state_d = ST_OUT;
      ST_OUT: if (!sts_i.out_busy) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.sel_a = OP_UX;
    cmd_o.sel_b = OP_UX;
    cmd_o.acc_sh = SH_0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_CROSS_M: begin
        cmd_o.mul_go = 1'b1;
        unique case (k_q)
          KW'(0): begin cmd_o.sel_a = OP_UY; cmd_o.sel_b = OP_VZ; end
          KW'(1): begin cmd_o.sel_a = OP_UZ; cmd_o.sel_b = OP_VY; end
          KW'(2): begin cmd_o.sel_a = OP_UZ; cmd_o.sel_b = OP_VX; end
          KW'(3): begin cmd_o.sel_a = OP_UX; cmd_o.sel_b = OP_VZ; end
          KW'(4): begin cmd_o.sel_a = OP_UX; cmd_o.sel_b = OP_VY; end
          default: begin cmd_o.sel_a = OP_UY; cmd_o.sel_b = OP_VX; end
        endcase
      end
      ST_CROSS_A: begin
        cmd_o.acc_en = 1'b1;
        cmd_o.acc_clr = !k_q[0];
        cmd_o.acc_sub = k_q[0];
        cmd_o.comp = k_q[2:1];
        cmd_o.n_wr = k_q[0];
      end
      ST_SQ_M: begin
        cmd_o.mul_go = 1'b1;
        cmd_o.comp = sq_comp;
        cmd_o.sel_a = (sq_j == 2'd2) ? OP_ML : OP_MH;
        cmd_o.sel_b = (sq_j == 2'd0) ? OP_MH : OP_ML;
      end
      ST_SQ_A: begin
        cmd_o.acc_en = 1'b1;
        cmd_o.acc_clr = (k_q == '0);
        unique case (sq_j)
          2'd0:    cmd_o.acc_sh = SH_34;
          2'd1:    cmd_o.acc_sh = SH_18;
          default: cmd_o.acc_sh = SH_0;
        endcase
      end
      ST_SQRT_INIT: cmd_o.sqrt_init = 1'b1;
      ST_SQRT: cmd_o.sqrt_step = 1'b1;
      ST_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        cmd_o.comp = comp_q;
      end
      ST_DIV_STEP: cmd_o.div_step = 1'b1;
      ST_DIV_WR: begin
        cmd_o.un_wr = 1'b1;
        cmd_o.comp = comp_q;
      end
      ST_DOT_M: begin
        cmd_o.mul_go = 1'b1;
        unique case (k_q)
          KW'(0):  begin cmd_o.sel_a = OP_UN0; cmd_o.sel_b = OP_AX; end
          KW'(1):  begin cmd_o.sel_a = OP_UN1; cmd_o.sel_b = OP_AY; end
          default: begin cmd_o.sel_a = OP_UN2; cmd_o.sel_b = OP_AZ; end
        endcase
      end
      ST_DOT_A: begin
        cmd_o.acc_en = 1'b1;
        cmd_o.acc_clr = (k_q == '0);
      end
      ST_OFF: cmd_o.off_wr = 1'b1;
      ST_SRCH_INIT: cmd_o.srch_init = 1'b1;
      ST_SRCH: cmd_o.srch_step = 1'b1;
      ST_TBL_WR: cmd_o.tbl_wr = 1'b1;
      ST_OUT: cmd_o.out_load = !sts_i.out_busy;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q <= '0;
      comp_q <= '0;
    end else begin
      state_q <= state_d;
      k_q <= k_d;
      comp_q <= comp_d;
    end
  end

endmodule

// ===== hw/rtl/tpd_datapath.sv =====
// Arithmetic, plane table and result register of the triangle plane dedup block.
module tpd_datapath #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  tpd_pkg::dp_cmd_t                        cmd_i,
  output tpd_pkg::dp_sts_t                        sts_o,
  input  logic                                    start_new_set_i,
  input  logic signed [tpd_pkg::CoordW-1:0]       a_x_i,
  input  logic signed [tpd_pkg::CoordW-1:0]       a_y_i,
  input  logic signed [tpd_pkg::CoordW-1:0]       a_z_i,
  input  logic signed [tpd_pkg::CoordW-1:0]       b_x_i,
  input  logic signed [tpd_pkg::CoordW-1:0]       b_y_i,
  input  logic signed [tpd_pkg::CoordW-1:0]       b_z_i,
  input  logic signed [tpd_pkg::CoordW-1:0]       c_x_i,
  input  logic signed [tpd_pkg::CoordW-1:0]       c_y_i,
  input  logic signed [tpd_pkg::CoordW-1:0]       c_z_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic                                    plane_valid_o,
  output logic signed [tpd_pkg::UnitW-1:0]        unit_nx_o,
  output logic signed [tpd_pkg::UnitW-1:0]        unit_ny_o,
  output logic signed [tpd_pkg::UnitW-1:0]        unit_nz_o,
  output logic signed [tpd_pkg::OffW-1:0]         plane_offset_o,
  output logic                                    is_new_o,
  output logic                                    table_full_o,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]        kept_count_o
);
  import tpd_pkg::*;

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [CW-1:0] Depth = CW'(TABLE_DEPTH);

  logic signed [DiffW-1:0]  ux_q, uy_q, uz_q, vx_q, vy_q, vz_q;
  logic signed [CoordW-1:0] ax_q, ay_q, az_q;
  logic signed [NormW-1:0]  n_q [3];
  logic signed [ProdW-1:0]  prod_q;
  logic signed [AccW-1:0]   acc_q, acc_d, acc_base, addend;
  logic [AccW-1:0]          rad_q;
  logic [SqRemW-1:0]        sq_rem_q, sq_r2, sq_trial;
  logic [RootW-1:0]         root_q;
  logic [DvRemW-1:0]        dv_rem_q;
  logic [DvRemW:0]          dv_r2, dv_root;
  logic [QuoW-1:0]          dq_q, quo_q;
  logic signed [UnitW-1:0]  un_q [3];
  logic signed [OffW-1:0]   off_q;
  logic signed [NormW-1:0]  n_sel;
  logic [MagW-1:0]          mag;
  logic signed [OpW-1:0]    op_a, op_b;
  logic [CW-1:0]            cnt_q, idx_q;
  logic                     pend_q, hit_q, full_q;
  logic [EntryW-1:0]        mem [TABLE_DEPTH];
  logic [EntryW-1:0]        rd_q, entry;
  logic                     nz;

  function automatic logic signed [OpW-1:0] pick(
    input opsel_e sel,
    input logic signed [DiffW-1:0] ux, uy, uz, vx, vy, vz,
    input logic [MagW-1:0] m,
    input logic signed [UnitW-1:0] u0, u1, u2,
    input logic signed [CoordW-1:0] ax, ay, az
  );
    logic signed [OpW-1:0] r;
    unique case (sel)
      OP_UX:   r = OpW'(ux);
      OP_UY:   r = OpW'(uy);
      OP_UZ:   r = OpW'(uz);
      OP_VX:   r = OpW'(vx);
      OP_VY:   r = OpW'(vy);
      OP_VZ:   r = OpW'(vz);
      OP_MH:   r = {1'b0, m[MagW-1:HalfW]};
      OP_ML:   r = {1'b0, m[HalfW-1:0]};
      OP_UN0:  r = OpW'(u0);
      OP_UN1:  r = OpW'(u1);
      OP_UN2:  r = OpW'(u2);
      OP_AX:   r = OpW'(ax);
      OP_AY:   r = OpW'(ay);
      OP_AZ:   r = OpW'(az);
      default: r = '0;
    endcase
    return r;
  endfunction

  assign nz = (n_q[0] != '0) || (n_q[1] != '0) || (n_q[2] != '0);

  always_comb begin
    unique case (cmd_i.comp)
      2'd0:    n_sel = n_q[0];
      2'd1:    n_sel = n_q[1];
      default: n_sel = n_q[2];
    endcase
  end
  assign mag = n_sel[NormW-1] ? MagW'(-n_sel) : MagW'(n_sel);

  assign op_a = pick(cmd_i.sel_a, ux_q, uy_q, uz_q, vx_q, vy_q, vz_q, mag,
                     un_q[0], un_q[1], un_q[2], ax_q, ay_q, az_q);
  assign op_b = pick(cmd_i.sel_b, ux_q, uy_q, uz_q, vx_q, vy_q, vz_q, mag,
                     un_q[0], un_q[1], un_q[2], ax_q, ay_q, az_q);

  always_comb begin
    acc_base = cmd_i.acc_clr ? '0 : acc_q;
    unique case (cmd_i.acc_sh)
      SH_18:   addend = AccW'(prod_q) <<< 18;
      SH_34:   addend = AccW'(prod_q) <<< 34;
      default: addend = AccW'(prod_q);
    endcase
    acc_d = cmd_i.acc_sub ? acc_base - addend : acc_base + addend;
  end

  assign sq_r2    = {sq_rem_q[SqRemW-3:0], rad_q[AccW-1:AccW-2]};
  assign sq_trial = {2'b00, root_q, 2'b01};
  assign dv_r2    = {dv_rem_q, dq_q[QuoW-1]};
  assign dv_root  = (DvRemW+1)'(root_q);
  assign entry    = {un_q[0], un_q[1], un_q[2], off_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ux_q <= DiffW'(c_x_i) - DiffW'(a_x_i);
      uy_q <= DiffW'(c_y_i) - DiffW'(a_y_i);
      uz_q <= DiffW'(c_z_i) - DiffW'(a_z_i);
      vx_q <= DiffW'(b_x_i) - DiffW'(a_x_i);
      vy_q <= DiffW'(b_y_i) - DiffW'(a_y_i);
      vz_q <= DiffW'(b_z_i) - DiffW'(a_z_i);
      ax_q <= a_x_i;
      ay_q <= a_y_i;
      az_q <= a_z_i;
    end
    if (cmd_i.mul_go) prod_q <= op_a * op_b;
    if (cmd_i.acc_en) acc_q <= acc_d;
    if (cmd_i.n_wr) begin
      unique case (cmd_i.comp)
        2'd0:    n_q[0] <= NormW'(acc_d);
        2'd1:    n_q[1] <= NormW'(acc_d);
        default: n_q[2] <= NormW'(acc_d);
      endcase
    end
    if (cmd_i.sqrt_init) begin
      rad_q <= acc_q;
      sq_rem_q <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      rad_q <= rad_q << 2;
      if (sq_r2 >= sq_trial) begin
        sq_rem_q <= sq_r2 - sq_trial;
        root_q <= {root_q[RootW-2:0], 1'b1};
      end else begin
        sq_rem_q <= sq_r2;
        root_q <= {root_q[RootW-2:0], 1'b0};
      end
    end
    if (cmd_i.div_init) begin
      dv_rem_q <= DvRemW'(mag[MagW-1:1]);
      dq_q <= {mag[0], {(QuoW-1){1'b0}}};
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      dq_q <= dq_q << 1;
      if (dv_r2 >= dv_root) begin
        dv_rem_q <= DvRemW'(dv_r2 - dv_root);
        quo_q <= {quo_q[QuoW-2:0], 1'b1};
      end else begin
        dv_rem_q <= DvRemW'(dv_r2);
        quo_q <= {quo_q[QuoW-2:0], 1'b0};
      end
    end
    if (cmd_i.un_wr) begin
      unique case (cmd_i.comp)
        2'd0:    un_q[0] <= n_sel[NormW-1] ? -UnitW'(quo_q) : UnitW'(quo_q);
        2'd1:    un_q[1] <= n_sel[NormW-1] ? -UnitW'(quo_q) : UnitW'(quo_q);
        default: un_q[2] <= n_sel[NormW-1] ? -UnitW'(quo_q) : UnitW'(quo_q);
      endcase
    end
    if (cmd_i.off_wr) off_q <= acc_q[FracW+OffW-1:FracW];
    rd_q <= mem[idx_q[AW-1:0]];
    if (cmd_i.tbl_wr && !hit_q && (cnt_q < Depth)) mem[cnt_q[AW-1:0]] <= entry;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
      pend_q <= 1'b0;
      hit_q <= 1'b0;
      full_q <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        full_q <= 1'b0;
        if (start_new_set_i) cnt_q <= '0;
      end
      if (cmd_i.srch_init) begin
        idx_q <= '0;
        pend_q <= 1'b0;
        hit_q <= 1'b0;
      end else if (cmd_i.srch_step) begin
        if ((idx_q < cnt_q) && !hit_q) begin
          idx_q <= idx_q + CW'(1);
          pend_q <= 1'b1;
        end else begin
          pend_q <= 1'b0;
        end
        if (pend_q && (rd_q == entry)) hit_q <= 1'b1;
      end
      if (cmd_i.tbl_wr && !hit_q) begin
        if (cnt_q < Depth) cnt_q <= cnt_q + CW'(1);
        else full_q <= 1'b1;
      end
      if (cmd_i.out_load) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      plane_valid_o <= nz;
      unit_nx_o <= nz ? un_q[0] : '0;
      unit_ny_o <= nz ? un_q[1] : '0;
      unit_nz_o <= nz ? un_q[2] : '0;
      plane_offset_o <= nz ? off_q : '0;
      is_new_o <= nz && !hit_q;
      table_full_o <= nz && full_q;
      kept_count_o <= cnt_q;
    end
  end

  assign sts_o.nz = nz;
  assign sts_o.srch_done = hit_q || (!pend_q && (idx_q >= cnt_q));
  assign sts_o.out_busy = out_valid_o && !out_ready_i;

endmodule

// ===== hw/rtl/triangle_plane_dedup.sv =====
// Top level of the triangle plane dedup block: controller plus datapath.
//
//   channel | signals                          | dir | content
//   in      | in_valid_i / in_ready_o          | in  | start flag and three vertices
//   out     | out_valid_o / out_ready_i        | out | plane, new flag, full flag, count
//
// A face's time grows with the number of kept planes searched in the one-port table,
// which holds up to 256 planes by default; the shared 18x18 multiplier, the 36-step
// root and three 15-step divisions set the fixed part. Reset empties the table at once.
// A held result stalls the next result only; a new face is taken meanwhile.
module triangle_plane_dedup #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                start_new_set_i,
  input  logic signed [tpd_pkg::CoordW-1:0]   a_x_i,
  input  logic signed [tpd_pkg::CoordW-1:0]   a_y_i,
  input  logic signed [tpd_pkg::CoordW-1:0]   a_z_i,
  input  logic signed [tpd_pkg::CoordW-1:0]   b_x_i,
  input  logic signed [tpd_pkg::CoordW-1:0]   b_y_i,
  input  logic signed [tpd_pkg::CoordW-1:0]   b_z_i,
  input  logic signed [tpd_pkg::CoordW-1:0]   c_x_i,
  input  logic signed [tpd_pkg::CoordW-1:0]   c_y_i,
  input  logic signed [tpd_pkg::CoordW-1:0]   c_z_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                plane_valid_o,
  output logic signed [tpd_pkg::UnitW-1:0]    unit_nx_o,
  output logic signed [tpd_pkg::UnitW-1:0]    unit_ny_o,
  output logic signed [tpd_pkg::UnitW-1:0]    unit_nz_o,
  output logic signed [tpd_pkg::OffW-1:0]     plane_offset_o,
  output logic                                is_new_o,
  output logic                                table_full_o,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]    kept_count_o
);
  import tpd_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  tpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tpd_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .start_new_set_i (start_new_set_i),
    .a_x_i           (a_x_i),
    .a_y_i           (a_y_i),
    .a_z_i           (a_z_i),
    .b_x_i           (b_x_i),
    .b_y_i           (b_y_i),
    .b_z_i           (b_z_i),
    .c_x_i           (c_x_i),
    .c_y_i           (c_y_i),
    .c_z_i           (c_z_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .plane_valid_o   (plane_valid_o),
    .unit_nx_o       (unit_nx_o),
    .unit_ny_o       (unit_ny_o),
    .unit_nz_o       (unit_nz_o),
    .plane_offset_o  (plane_offset_o),
    .is_new_o        (is_new_o),
    .table_full_o    (table_full_o),
    .kept_count_o    (kept_count_o)
  );

endmodule

// ===== dv/tb.sv =====
// Testbench for the triangle plane dedup block: random and directed faces, scoreboard check.
`timescale 1ns / 1ps

class plane_scoreboard;
  typedef struct packed {
    logic               valid;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic signed [16:0] off;
    logic               is_new;
    logic               full;
    logic [8:0]         count;
  } plane_t;

  int unsigned       depth;
  logic signed [15:0] kept_n[256][3];
  logic signed [16:0] kept_off[256];
  int unsigned       kept;
  plane_t            pending[$];
  int                mismatches;
  int                checked;
  int                fresh_seen;
  int                full_seen;
  int                flat_seen;

  function new(int unsigned d);
    depth = d;
    kept = 0;
    mismatches = 0;
    checked = 0;
    fresh_seen = 0;
    full_seen = 0;
    flat_seen = 0;
  endfunction

  static function longint unsigned root_of(logic [71:0] s);
    logic [71:0] r;
    logic [71:0] c;
    r = 0;
    for (int b = 35; b >= 0; b--) begin
      c = r | (72'd1 << b);
      if (c * c <= s) r = c;
    end
    return r[63:0];
  endfunction

  function void note_face(logic start, logic signed [15:0] v[9]);
    plane_t p;
    longint ux, uy, uz, wx, wy, wz;
    longint n[3];
    longint dot;
    longint unsigned m, rt, q;
    logic [71:0] sum;
    logic signed [15:0] un[3];
    logic signed [16:0] off;
    bit hit;
    p = '0;
    if (start) kept = 0;
    ux = v[6] - v[0]; uy = v[7] - v[1]; uz = v[8] - v[2];
    wx = v[3] - v[0]; wy = v[4] - v[1]; wz = v[5] - v[2];
    n[0] = uy * wz - uz * wy;
    n[1] = uz * wx - ux * wz;
    n[2] = ux * wy - uy * wx;
    if (n[0] != 0 || n[1] != 0 || n[2] != 0) begin
      sum = 0;
      for (int k = 0; k < 3; k++) begin
        m = n[k] < 0 ? -n[k] : n[k];
        sum += 72'(m) * 72'(m);
      end
      rt = root_of(sum);
      for (int k = 0; k < 3; k++) begin
        m = n[k] < 0 ? -n[k] : n[k];
        q = (m << 14) / rt;
        un[k] = n[k] < 0 ? -16'(q) : 16'(q);
      end
      dot = longint'(un[0]) * v[0] + longint'(un[1]) * v[1] + longint'(un[2]) * v[2];
      off = 17'(dot >>> 14);
      p.valid = 1;
      p.nx = un[0]; p.ny = un[1]; p.nz = un[2]; p.off = off;
      hit = 0;
      for (int i = 0; i < kept; i++)
        if (kept_n[i][0] == un[0] && kept_n[i][1] == un[1] && kept_n[i][2] == un[2] &&
            kept_off[i] == off) hit = 1;
      p.is_new = !hit;
      if (!hit) begin
        if (kept < depth) begin
          kept_n[kept][0] = un[0]; kept_n[kept][1] = un[1]; kept_n[kept][2] = un[2];
          kept_off[kept] = off;
          kept++;
        end else p.full = 1;
      end
    end
    p.count = 9'(kept);
    pending = {pending, p};
  endfunction

  function void check_plane(plane_t got);
    plane_t want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %p", got);
      return;
    end
    want = pending.pop_front();
    checked++;
    if (got.is_new) fresh_seen++;
    if (got.full) full_seen++;
    if (!got.valid) flat_seen++;
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("mismatch: expected %p, actual %p", want, got);
    end
  endfunction
endclass

module tb;
  import tpd_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0, in_ready_o;
  logic start_new_set_i = 0;
  logic signed [15:0] a_x_i = 0, a_y_i = 0, a_z_i = 0, b_x_i = 0, b_y_i = 0, b_z_i = 0;
  logic signed [15:0] c_x_i = 0, c_y_i = 0, c_z_i = 0;
  logic out_valid_o, out_ready_i = 0;
  logic plane_valid_o, is_new_o, table_full_o;
  logic signed [15:0] unit_nx_o, unit_ny_o, unit_nz_o;
  logic signed [16:0] plane_offset_o;
  logic [8:0] kept_count_o;

  triangle_plane_dedup #(.TABLE_DEPTH(256)) dut (.*);

  plane_scoreboard sb = new(256);
  int idle_cycles = 0;
  bit timed_out = 0;
  bit calm = 0;
  logic signed [15:0] pool[$];

  initial forever #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sb.note_face(start_new_set_i, '{a_x_i, a_y_i, a_z_i, b_x_i, b_y_i, b_z_i,
                                     c_x_i, c_y_i, c_z_i});
      idle_cycles <= 0;
    end else if (out_valid_o && out_ready_i) idle_cycles <= 0;
    else if (rst_ni) idle_cycles <= idle_cycles + 1;
    if (out_valid_o && out_ready_i)
      sb.check_plane('{plane_valid_o, unit_nx_o, unit_ny_o, unit_nz_o, plane_offset_o,
                       is_new_o, table_full_o, kept_count_o});
    if (idle_cycles > 20000) timed_out <= 1;
  end

  always @(negedge clk_i) out_ready_i <= calm ? 1'b1 : ($urandom_range(99) >= 29);

  task automatic send_face(bit start, logic signed [15:0] v[9]);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 29) @(negedge clk_i);
    in_valid_i <= 1;
    start_new_set_i <= start;
    {a_x_i, a_y_i, a_z_i} <= {v[0], v[1], v[2]};
    {b_x_i, b_y_i, b_z_i} <= {v[3], v[4], v[5]};
    {c_x_i, c_y_i, c_z_i} <= {v[6], v[7], v[8]};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    in_valid_i <= 0;
  endtask

  function automatic logic signed [15:0] coord(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(40)) - 20);
      default: return pool.size() ? pool[$urandom_range(pool.size() - 1)] : 16'($urandom);
    endcase
  endfunction

  task automatic random_face();
    logic signed [15:0] v[9];
    int mode;
    mode = $urandom_range(2);
    foreach (v[i]) v[i] = coord(mode);
    if ($urandom_range(9) == 0) begin
      v[3] = v[0]; v[4] = v[1]; v[5] = v[2];
    end
    foreach (v[i]) if (pool.size() < 32) pool = {pool, v[i]};
    send_face($urandom_range(49) == 0, v);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0 && !timed_out) @(posedge clk_i);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    send_face(1, '{0, 0, 0, 1, 0, 0, 0, 1, 0});
    send_face(0, '{0, 0, 0, 1, 0, 0, 0, 1, 0});
    send_face(0, '{5, 5, 5, 5, 5, 5, 5, 5, 5});
    send_face(0, '{0, 0, 0, 1, 1, 1, 2, 2, 2});
    send_face(0, '{-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, 32767});
    send_face(0, '{32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, -32768});
    send_face(0, '{32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767, -32768});
    send_face(0, '{-32768, 0, 0, 32767, 0, 0, 0, 32767, 0});
    send_face(0, '{1, 2, 3, 3, 2, 1, -7, 9, -11});
    send_face(1, '{0, 0, 7, 0, 1, 7, 1, 0, 7});
    send_face(0, '{-1, -1, -1, -1, -1, -1, 0, 0, 0});
    drain();
    calm = 1;
    for (int i = 0; i < 150; i++) random_face();
    calm = 0;
    drain();
    // fill the table past its depth with distinct small planes
    for (int i = 0; i < 270 && !timed_out; i++)
      send_face(i == 0, '{16'(i), 0, 0, 16'(i), 1, 0, 16'(i), 0, 1});
    for (int i = 0; i < 700 && !timed_out; i++) random_face();
    drain();
    repeat (700) @(posedge clk_i);
    $display("tb: %0d faces checked, %0d new planes, %0d table full, %0d degenerate",
             sb.checked, sb.fresh_seen, sb.full_seen, sb.flat_seen);
    if (!timed_out && sb.mismatches == 0 && sb.pending.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    wait (timed_out);
    $display("tb: failure");
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/tpd_pkg.sv
hw/rtl/tpd_ctrl.sv
hw/rtl/tpd_datapath.sv
hw/rtl/triangle_plane_dedup.sv
dv/tb.sv
